### design/srw_pkg.sv
// ----------------------------------------------------------------------------
// srw_pkg
// shared types and constants of the selective-repeat window sender
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int SRW_WINDOW = 8;
    localparam int QDEPTH     = 2;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_LOST  = 2'd1;
    localparam logic [1:0] OP_ACK   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic REG_TOTAL_BYTES   = 1'b0;
    localparam logic REG_PAYLOAD_BYTES = 1'b1;

    localparam logic [15:0] TOTAL_BYTES_RST   = 16'd1024;
    localparam logic [7:0]  PAYLOAD_BYTES_RST = 8'd32;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] lost_seq;
    } srw_in_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  length;
        logic [15:0] window_start;
        logic [15:0] window_finish;
        logic        final_data;
        logic        last;
    } srw_out_t;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_LOST,
        KIND_ACK
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] lost_seq;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } srw_q_t;

    typedef struct packed {
        logic [15:0] total_bytes;
        logic [7:0]  payload_bytes;
    } srw_cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } st_t;

endpackage

### design/srw_front.sv
// ----------------------------------------------------------------------------
// srw_front
// accepts commands, decodes the opcode and queues all but OP_NONE for the back end
// ----------------------------------------------------------------------------
module srw_front
    import srw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  srw_in_t item,
    output srw_q_t  q,
    input  logic    pop
);

    localparam int QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W = $clog2(QDEPTH + 1);

    cmd_t              fifo_mem [QDEPTH];
    logic [QP_W-1:0]   wr_ptr_reg;
    logic [QP_W-1:0]   wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg;
    logic [QP_W-1:0]   rd_ptr_next;
    logic [QC_W-1:0]   count_reg;
    logic [QC_W-1:0]   count_next;
    logic              keep;
    logic              push;
    logic              do_pop;
    cmd_t              cmd_in;

    assign busy = (count_reg == QC_W'(QDEPTH));

    // decode
    always_comb
    begin
        keep           = 1'b1;
        cmd_in.kind    = KIND_START;
        cmd_in.lost_seq = item.lost_seq;
        unique case (item.opcode)
            OP_START: cmd_in.kind = KIND_START;
            OP_LOST:  cmd_in.kind = KIND_LOST;
            OP_ACK:   cmd_in.kind = KIND_ACK;
            OP_NONE:  keep = 1'b0;
            default:  keep = 1'b0;
        endcase
    end

    assign push   = start && !busy && keep;
    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    assign q.valid = (count_reg != '0);
    assign q.cmd   = fifo_mem[rd_ptr_reg];

endmodule

### design/srw_back.sv
// ----------------------------------------------------------------------------
// srw_back
// lost list, window sequencer and issue / multiply / sizing pipeline
// ----------------------------------------------------------------------------
module srw_back
    import srw_pkg::*;
#(
    parameter int WINDOW = SRW_WINDOW
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  srw_cfg_t cfg,
    input  srw_q_t   q,
    output logic     pop,
    output logic     strobe,
    output srw_out_t result
);

    localparam int CNT_W  = $clog2(WINDOW);
    localparam int ISS_W  = $clog2(WINDOW + 1);
    localparam int LIDX_W = (WINDOW - 1 > 1) ? $clog2(WINDOW - 1) : 1;

    st_t               state_reg;
    st_t               state_next;

    logic [15:0]       next_new_seq_reg;
    logic [CNT_W-1:0]  lost_count_reg;
    logic [15:0]       lost_mem [WINDOW-1];

    logic [15:0]       win_start_reg;
    logic [15:0]       win_finish_reg;
    logic [CNT_W-1:0]  win_lost_reg;

    logic [ISS_W-1:0]  a_issued_reg;
    logic [CNT_W-1:0]  a_used_reg;
    logic [15:0]       a_seq_reg;

    logic              b_valid_reg;
    logic              b_from_lost_reg;
    logic              b_last_slot_reg;
    logic [15:0]       b_new_seq_reg;
    logic [15:0]       b_mem_q_reg;

    logic              c_valid_reg;
    logic              c_from_lost_reg;
    logic              c_last_slot_reg;
    logic [15:0]       c_seq_reg;
    logic [23:0]       c_prod_reg;

    logic              begin_win;
    logic              is_start;
    logic              lost_wr;
    logic [15:0]       begin_start;
    logic [CNT_W-1:0]  begin_lost;
    logic              a_issue;
    logic              a_from_lost;
    logic [15:0]       b_n;
    logic [24:0]       c_end_byte;
    logic              c_fin;
    logic [23:0]       c_rem;
    logic [7:0]        c_len;
    logic              c_end;

    assign pop       = (state_reg == ST_IDLE) && q.valid;
    assign is_start  = (q.cmd.kind == KIND_START);
    assign begin_win = pop && (is_start || (q.cmd.kind == KIND_ACK));
    assign lost_wr   = pop && (q.cmd.kind == KIND_LOST)
                       && (lost_count_reg < CNT_W'(WINDOW - 1));

    assign begin_start = is_start ? '0 : next_new_seq_reg;
    assign begin_lost  = is_start ? '0 : lost_count_reg;

    // sizing of the descriptor in the last stage
    assign c_end_byte = {1'b0, c_prod_reg} + 25'(cfg.payload_bytes);
    assign c_fin      = (c_end_byte >= 25'(cfg.total_bytes));
    assign c_rem      = (24'(cfg.total_bytes) > c_prod_reg)
                        ? (24'(cfg.total_bytes) - c_prod_reg) : '0;
    assign c_len      = (c_rem > 24'(cfg.payload_bytes)) ? cfg.payload_bytes : c_rem[7:0];
    assign c_end      = c_valid_reg && (c_fin || c_last_slot_reg);

    assign a_issue     = (state_reg == ST_RUN) && (a_issued_reg < ISS_W'(WINDOW)) && !c_end;
    assign a_from_lost = (a_used_reg < win_lost_reg);

    assign b_n = b_from_lost_reg ? b_mem_q_reg : b_new_seq_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (begin_win)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (c_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            next_new_seq_reg <= '0;
            lost_count_reg   <= '0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            b_valid_reg <= a_issue;
            c_valid_reg <= b_valid_reg && !c_end;
            if (begin_win)
            begin
                lost_count_reg <= '0;
                if (is_start)
                begin
                    next_new_seq_reg <= '0;
                end
            end
            else if (lost_wr)
            begin
                lost_count_reg <= lost_count_reg + 1'b1;
            end
            if (c_valid_reg && !c_from_lost_reg)
            begin
                next_new_seq_reg <= c_seq_reg + 16'd1;
            end
        end
    end

    // window and issue stage
    always_ff @(posedge clk)
    begin
        if (begin_win)
        begin
            win_start_reg  <= begin_start;
            win_finish_reg <= begin_start + 16'(WINDOW - 1) - 16'(begin_lost);
            win_lost_reg   <= begin_lost;
            a_issued_reg   <= '0;
            a_used_reg     <= '0;
            a_seq_reg      <= begin_start;
        end
        else if (a_issue)
        begin
            a_issued_reg <= a_issued_reg + 1'b1;
            if (a_from_lost)
            begin
                a_used_reg <= a_used_reg + 1'b1;
            end
            else
            begin
                a_seq_reg <= a_seq_reg + 16'd1;
            end
        end
    end

    // lost list
    always_ff @(posedge clk)
    begin
        if (lost_wr)
        begin
            lost_mem[lost_count_reg[LIDX_W-1:0]] <= q.cmd.lost_seq;
        end
        if (a_issue && a_from_lost)
        begin
            b_mem_q_reg <= lost_mem[a_used_reg[LIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_issue)
        begin
            b_from_lost_reg <= a_from_lost;
            b_last_slot_reg <= (a_issued_reg == ISS_W'(WINDOW - 1));
            b_new_seq_reg   <= a_seq_reg;
        end
        if (b_valid_reg)
        begin
            c_from_lost_reg <= b_from_lost_reg;
            c_last_slot_reg <= b_last_slot_reg;
            c_seq_reg       <= b_n;
            c_prod_reg      <= 24'(b_n) * 24'(cfg.payload_bytes);
        end
    end

    assign strobe               = c_valid_reg;
    assign result.seq           = c_seq_reg;
    assign result.length        = c_len;
    assign result.window_start  = win_start_reg;
    assign result.window_finish = win_finish_reg;
    assign result.final_data    = c_fin;
    assign result.last          = c_fin || c_last_slot_reg;

endmodule

### design/selective_repeat_window_sender_core.sv
// ----------------------------------------------------------------------------
// selective_repeat_window_sender_core
// plans the packet windows of a selective-repeat transfer
//
// channel   direction  handshake                 payload
// command   in         start high, busy low      item   (srw_in_t)
// result    out        strobe, one cycle         result (srw_out_t)
// config    in         cfg_we                    cfg_index, cfg_data
//
// a lost-entry command is taken by the back end while it is idle; a start or ack
// command is dequeued, then its descriptors go one per cycle through
// the issue / multiply / sizing pipeline, at most WINDOW of them
// busy rises only when the two-entry command queue is full
// async reset clears progress, the lost count and the queue; the lost list
// itself is not cleared
// ----------------------------------------------------------------------------
module selective_repeat_window_sender_core
    import srw_pkg::*;
#(
    parameter int WINDOW = SRW_WINDOW
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  srw_in_t     item,
    output logic        strobe,
    output srw_out_t    result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] total_bytes_reg;
    logic [7:0]  payload_bytes_reg;
    srw_cfg_t    cfg;
    srw_q_t      q;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_bytes_reg   <= TOTAL_BYTES_RST;
            payload_bytes_reg <= PAYLOAD_BYTES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOTAL_BYTES:   total_bytes_reg   <= cfg_data;
                REG_PAYLOAD_BYTES: payload_bytes_reg <= cfg_data[7:0];
                default:           total_bytes_reg   <= total_bytes_reg;
            endcase
        end
    end

    assign cfg.total_bytes   = total_bytes_reg;
    assign cfg.payload_bytes = payload_bytes_reg;

    srw_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .q     (q),
        .pop   (pop)
    );

    srw_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .q      (q),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

### design/srw_checker.sv
// ----------------------------------------------------------------------------
// srw_checker
// port-level checks on the result stream of the window sender
// ----------------------------------------------------------------------------
module srw_checker
    import srw_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     strobe,
    input srw_out_t result
);

    // the end of the data always closes the window
    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.final_data |-> result.last)
        else $error("final descriptor without last");

    // descriptors of one window come back to back
    a_window_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("gap inside a window");

    a_window_fields: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> $stable(result.window_start)
                                   && $stable(result.window_finish))
        else $error("window bounds changed inside a window");

    // a new window needs at least a dequeue and the pipeline fill
    a_window_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |=> !strobe)
        else $error("window followed without a gap");

endmodule

bind selective_repeat_window_sender_core srw_checker u_srw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .result (result)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the selective-repeat window sender against its own window planner
//
// a directed table covers the register extremes, every opcode, a full lost
// list, an early stop on a resent final packet, windows past the end of the
// data and a zero payload register; random sessions follow, each with fresh
// register values, a start and rounds of lost reports and acks; every
// descriptor is compared field by field with the planned or the typed one
// ----------------------------------------------------------------------------
module testbench;
    import srw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN          = SRW_WINDOW;
    localparam int DRAIN        = 3 * (WIN + 3);
    localparam int LIMIT        = 1000000;
    localparam int ITEMS_TARGET = 350;

    typedef struct packed {
        logic        is_cfg;
        logic        cfg_idx;
        logic [15:0] cfg_val;
        srw_in_t     cmd;
        logic        has_typed;
        srw_out_t    typed;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    srw_in_t     item;
    logic        strobe;
    srw_out_t    result;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    logic        typed_on;
    srw_out_t    typed_descr;

    srw_out_t    descr_q[$];
    srw_out_t    plan_q[$];
    step_t       steps[$];

    logic [15:0] nxt_seq = 16'd0;
    logic [15:0] lost_buf [0:WIN-1];
    int          lost_n = 0;
    logic [15:0] tot_b = TOTAL_BYTES_RST;
    logic [7:0]  pay_b = PAYLOAD_BYTES_RST;

    int          errors = 0;
    int          sent;
    int          cycles = 0;
    logic        gaps_on;
    logic [15:0] hint;

    selective_repeat_window_sender_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void size_packet(input logic [15:0] n, output logic [7:0] len,
                                        output logic fin);
        logic [31:0] first_b;
        logic [31:0] end_b;
        logic [31:0] rem;
        first_b = 32'(n) * 32'(pay_b);
        end_b   = first_b + 32'(pay_b);
        rem     = (32'(tot_b) > first_b) ? (32'(tot_b) - first_b) : 32'd0;
        if (rem > 32'(pay_b))
            rem = 32'(pay_b);
        len = rem[7:0];
        fin = (end_b >= 32'(tot_b));
    endfunction

    function automatic void plan_window();
        logic [15:0] ws;
        logic [15:0] wf;
        logic [15:0] span;
        logic [15:0] n;
        logic [7:0]  len;
        logic        fin;
        int          used;
        srw_out_t    d;
        ws   = nxt_seq;
        span = 16'(WIN - 1 - lost_n);
        wf   = ws + span;
        used = 0;
        fin  = 1'b0;
        for (int i = 0; i < WIN && !fin; i++)
        begin
            if (used < lost_n)
            begin
                n = lost_buf[used];
                used++;
            end
            else
            begin
                n       = nxt_seq;
                nxt_seq = nxt_seq + 16'd1;
            end
            size_packet(n, len, fin);
            d.seq           = n;
            d.length        = len;
            d.window_start  = ws;
            d.window_finish = wf;
            d.final_data    = fin;
            d.last          = fin || (i == WIN - 1);
            plan_q.push_back(d);
        end
    endfunction

    function automatic void accept_cmd(input srw_in_t cmd);
        case (cmd.opcode)
            OP_START:
            begin
                nxt_seq = 16'd0;
                lost_n  = 0;
                plan_window();
            end
            OP_LOST:
            begin
                if (lost_n < WIN - 1)
                begin
                    lost_buf[lost_n] = cmd.lost_seq;
                    lost_n++;
                end
            end
            OP_ACK:
            begin
                plan_window();
                lost_n = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        srw_out_t e;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (descr_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction: expected none, actual %h",
                             $time, result);
                    errors++;
                end
                else
                begin
                    e = descr_q.pop_front();
                    check_field("seq", e.seq, result.seq);
                    check_field("length", 16'(e.length), 16'(result.length));
                    check_field("window_start", e.window_start, result.window_start);
                    check_field("window_finish", e.window_finish, result.window_finish);
                    check_field("final_data", 16'(e.final_data), 16'(result.final_data));
                    check_field("last", 16'(e.last), 16'(result.last));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_TOTAL_BYTES)
                    tot_b = cfg_data;
                else
                    pay_b = cfg_data[7:0];
            end
            if (start && !busy)
            begin
                plan_q.delete();
                accept_cmd(item);
                if (typed_on)
                    descr_q.push_back(typed_descr);
                else
                    foreach (plan_q[i])
                        descr_q.push_back(plan_q[i]);
            end
        end
    end

    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (descr_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic issue(input srw_in_t cmd, input logic t_on, input srw_out_t t_val);
        start       <= 1'b1;
        item        <= cmd;
        typed_on    <= t_on;
        typed_descr <= t_val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send(input logic [1:0] op, input logic [15:0] s);
        srw_in_t cmd;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        cmd.opcode   = op;
        cmd.lost_seq = s;
        issue(cmd, 1'b0, '0);
        if (op != OP_NONE)
            sent++;
        if (op == OP_START)
            hint = 16'(WIN);
        else if (op == OP_ACK)
            hint = hint + 16'(WIN);
    endtask

    function automatic logic [15:0] pick_lost();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return hint - 16'($urandom_range(1, 2 * WIN));
    endfunction

    task automatic run_session(input logic gaps);
        int          rounds;
        int          k;
        logic [7:0]  pay;
        logic [15:0] tot;
        logic [7:0]  junk;
        gaps_on = gaps;
        case ($urandom_range(0, 9))
            0:       pay = 8'd0;
            1:       pay = 8'd255;
            2:       pay = 8'd1;
            default: pay = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 7))
            0:       tot = 16'd0;
            1:       tot = 16'hFFFF;
            2:       tot = 16'($urandom);
            default: tot = 16'(pay * $urandom_range(1, 24) + $urandom_range(0, pay));
        endcase
        junk = 8'($urandom);
        write_reg(REG_TOTAL_BYTES, tot);
        write_reg(REG_PAYLOAD_BYTES, {junk, pay});
        send(OP_START, 16'($urandom));
        rounds = $urandom_range(1, 6);
        repeat (rounds)
        begin
            if ($urandom_range(0, 4) == 0)
                k = $urandom_range(4, WIN + 2);
            else
                k = $urandom_range(0, 3);
            repeat (k) send(OP_LOST, pick_lost());
            if ($urandom_range(0, 9) == 0)
                send(OP_NONE, 16'($urandom));
            if ($urandom_range(0, 14) == 0)
                send(OP_START, 16'($urandom));
            send(OP_ACK, 16'($urandom));
        end
    endtask

    function automatic step_t cmd_step(input logic [1:0] op, input logic [15:0] s);
        step_t st;
        st              = '0;
        st.cmd.opcode   = op;
        st.cmd.lost_seq = s;
        return st;
    endfunction

    function automatic step_t cfg_step(input logic idx, input logic [15:0] v);
        step_t st;
        st         = '0;
        st.is_cfg  = 1'b1;
        st.cfg_idx = idx;
        st.cfg_val = v;
        return st;
    endfunction

    function automatic step_t typed_step(input logic [1:0] op, input logic [15:0] s,
                                         input logic [7:0] len, input logic [15:0] ws);
        step_t st;
        st                     = cmd_step(op, 16'd0);
        st.has_typed           = 1'b1;
        st.typed.seq           = s;
        st.typed.length        = len;
        st.typed.window_start  = ws;
        st.typed.window_finish = ws + 16'(WIN - 1);
        st.typed.final_data    = 1'b1;
        st.typed.last          = 1'b1;
        return st;
    endfunction

    initial
    begin : stimulus
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_index   = 1'b0;
        cfg_data    = 16'd0;
        typed_on    = 1'b0;
        typed_descr = '0;
        sent        = 0;
        gaps_on     = 1'b0;
        hint        = 16'd0;

        // defaults after reset, then a full lost list and a resent final packet
        steps.push_back(cmd_step(OP_START, 16'h0000));
        steps.push_back(cmd_step(OP_NONE, 16'hFFFF));
        steps.push_back(cmd_step(OP_LOST, 16'd3));
        steps.push_back(cmd_step(OP_LOST, 16'd5));
        steps.push_back(cmd_step(OP_ACK, 16'h0000));
        repeat (WIN - 1) steps.push_back(cmd_step(OP_LOST, 16'hFFFF));
        steps.push_back(cmd_step(OP_LOST, 16'h0000));
        steps.push_back(cmd_step(OP_ACK, 16'h0000));
        // no data at all, then windows past the end
        steps.push_back(cfg_step(REG_TOTAL_BYTES, 16'd0));
        steps.push_back(cfg_step(REG_PAYLOAD_BYTES, 16'h00FF));
        steps.push_back(typed_step(OP_START, 16'd0, 8'd0, 16'd0));
        steps.push_back(typed_step(OP_ACK, 16'd1, 8'd0, 16'd1));
        steps.push_back(cfg_step(REG_TOTAL_BYTES, 16'd100));
        steps.push_back(typed_step(OP_START, 16'd0, 8'd100, 16'd0));
        steps.push_back(cmd_step(OP_LOST, 16'h8000));
        steps.push_back(cmd_step(OP_ACK, 16'h0000));
        // largest dump, zero payload, single byte payload
        steps.push_back(cfg_step(REG_TOTAL_BYTES, 16'hFFFF));
        steps.push_back(cmd_step(OP_START, 16'h0000));
        steps.push_back(cmd_step(OP_ACK, 16'h0000));
        steps.push_back(cfg_step(REG_PAYLOAD_BYTES, 16'h0000));
        steps.push_back(cmd_step(OP_START, 16'h0000));
        steps.push_back(cfg_step(REG_PAYLOAD_BYTES, 16'h0001));
        steps.push_back(cfg_step(REG_TOTAL_BYTES, 16'd3));
        steps.push_back(cmd_step(OP_START, 16'h0000));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
                write_reg(steps[i].cfg_idx, steps[i].cfg_val);
            else
                issue(steps[i].cmd, steps[i].has_typed, steps[i].typed);
        end

        while (sent < ITEMS_TARGET)
            run_session((sent < ITEMS_TARGET - 60) && ($urandom_range(0, 2) != 0));

        settle();
        if (errors == 0 && descr_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
design/srw_pkg.sv
design/srw_front.sv
design/srw_back.sv
design/selective_repeat_window_sender_core.sv
design/srw_checker.sv
tb/testbench.sv
